/* rtl/chac_pkg.sv */
// Shared types, constants and the helper function of the codon-aligned hexamer counter.
// No dependencies; every module of the block imports this package.
package chac_pkg;

    // Request kinds carried in tuser
    localparam logic [1:0] REQ_TEXT = 2'd0;
    localparam logic [1:0] REQ_EOF  = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // Characters that steer the line parser
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_HEADER = 8'h3E;

    localparam int unsigned HEX_LEN   = 6;
    localparam int unsigned CODON     = 3;
    localparam int unsigned NUM_CODES = 4096;
    localparam int unsigned CODE_W    = 12;

    localparam logic [5:0] ALL_VALID = 6'h3F;

    // Stream payload widths
    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_CNT_W  = 32;
    localparam int unsigned OUT_TOT_W  = 48;
    localparam int unsigned OUT_DATA_W = OUT_CNT_W + 2 * OUT_TOT_W;

    // Running state of the current sequence
    typedef struct packed {
        logic [CODE_W-1:0] window;
        logic [5:0]        valid;
        logic [1:0]        phase;
        logic [2:0]        len;
    } t_seq;

    // Sequence state after one base, plus whether a hexamer is counted
    typedef struct packed {
        t_seq seq;
        logic hit;
    } t_push;

    // Counter memory operation issued by the parser
    typedef struct packed {
        logic              inc;
        logic              rd;
        logic [CODE_W-1:0] addr;
    } t_mem_op;

    function automatic t_push seq_push(input t_seq s, input logic [7:0] b);
        t_push      p;
        logic [1:0] code;
        logic       ok;
        ok   = 1'b1;
        code = 2'd0;
        case (b)
            8'h41, 8'h61: code = 2'd0;
            8'h43, 8'h63: code = 2'd1;
            8'h47, 8'h67: code = 2'd2;
            8'h54, 8'h74: code = 2'd3;
            default: ok = 1'b0;
        endcase
        p.seq.window = {s.window[CODE_W-3:0], (ok ? code : 2'd0)};
        p.seq.valid  = {s.valid[4:0], ok};
        p.seq.phase  = (s.phase == 2'(CODON - 1)) ? 2'd0 : s.phase + 2'd1;
        p.seq.len    = (s.len < 3'(HEX_LEN)) ? s.len + 3'd1 : s.len;
        p.hit        = (p.seq.phase == 2'd0) && (p.seq.len >= 3'(HEX_LEN))
                       && (p.seq.valid == ALL_VALID);
        return p;
    endfunction

endpackage

/* rtl/codon_aligned_hexamer_counter.sv */
// Codon-aligned hexamer counter: takes FASTA text one byte per transfer at one transfer per
// cycle while ready is high and counts every valid 6-base window that starts at a multiple of
// 3 in 4096 counters held in a one-port-write, registered-read memory. After reset the block
// clears every entry of that memory and holds o_s_axis_tready low meanwhile. A read request
// returns its counter and both totals through a three-entry result queue; outside the
// clearing pass, ready drops only when that queue and the read in flight fill it, so with
// the output taken every cycle the input keeps one item per cycle. The read-modify-write of
// a counter forwards the last write, so repeated hexamers in successive cycles count.
// Depends on chac_pkg, chac_parser, chac_count_mem and chac_out_fifo.
module codon_aligned_hexamer_counter #(
    parameter int COUNT_WIDTH = 32,
    parameter int TOTAL_WIDTH = 48
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // text_byte [7:0], counter_index [19:8], zero [23:20]
    input  logic [chac_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // req_type [1:0]
    input  logic [chac_pkg::IN_USER_W-1:0]  i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // count_value [31:0], hexamer_total [79:32], sequence_total [127:80]
    output logic [chac_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import chac_pkg::*;

    t_mem_op                op;
    logic                   accept, busy, res_valid;
    logic [TOTAL_WIDTH-1:0] hex_total, seq_total, res_hex, res_seqs;
    logic [COUNT_WIDTH-1:0] res_count;
    logic [1:0]             level;
    logic [2:0]             pending;
    logic [63:0]            cnt_ext, hex_ext, seq_ext;
    logic [OUT_DATA_W-1:0]  res_data;

    // Stall while clearing or when the queue could not take every result in flight
    assign pending         = {1'b0, level} + {2'b0, res_valid};
    assign o_s_axis_tready = !busy && (pending < 3'd3);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    chac_parser #(
        .TOTAL_WIDTH(TOTAL_WIDTH)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_req       (i_s_axis_tuser),
        .i_byte      (i_s_axis_tdata[7:0]),
        .i_index     (i_s_axis_tdata[19:8]),
        .o_op        (op),
        .o_hex_total (hex_total),
        .o_seq_total (seq_total)
    );

    chac_count_mem #(
        .COUNT_WIDTH(COUNT_WIDTH),
        .TOTAL_WIDTH(TOTAL_WIDTH)
    ) u_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_hex_total (hex_total),
        .i_seq_total (seq_total),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_count     (res_count),
        .o_hex_total (res_hex),
        .o_seq_total (res_seqs)
    );

    // Pack the low bits of counter and totals into the result
    always_comb begin
        cnt_ext  = 64'(res_count);
        hex_ext  = 64'(res_hex);
        seq_ext  = 64'(res_seqs);
        res_data = {seq_ext[OUT_TOT_W-1:0], hex_ext[OUT_TOT_W-1:0], cnt_ext[OUT_CNT_W-1:0]};
    end

    chac_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res_data),
        .i_pop   (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_data  (o_m_axis_tdata),
        .o_level (level)
    );

endmodule

/* rtl/chac_parser.sv */
// FASTA line parser: header skipping, CR/LF handling, codon window and the two totals.
// Depends on chac_pkg; issues at most one counter memory operation per accepted item.
module chac_parser #(
    parameter int TOTAL_WIDTH = 48
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [1:0]                i_req,
    input  logic [7:0]                i_byte,
    input  logic [chac_pkg::CODE_W-1:0] i_index,
    output chac_pkg::t_mem_op         o_op,
    output logic [TOTAL_WIDTH-1:0]    o_hex_total,
    output logic [TOTAL_WIDTH-1:0]    o_seq_total
);
    import chac_pkg::*;

    t_seq                   r_seq, n_seq;
    logic                   r_hdr, n_hdr;
    logic                   r_ls, n_ls;
    logic                   r_pcr, n_pcr;
    logic [TOTAL_WIDTH-1:0] r_hex, n_hex;
    logic [TOTAL_WIDTH-1:0] r_seqs, n_seqs;

    logic  push_a, push_b, finish;
    t_push pa, pb;
    t_seq  seq_a;

    // Decide what this byte does to the line state
    always_comb begin
        n_hdr  = r_hdr;
        n_ls   = r_ls;
        n_pcr  = r_pcr;
        push_a = 1'b0;
        push_b = 1'b0;
        finish = 1'b0;
        if (i_valid) begin
            case (i_req)
                REQ_TEXT: begin
                    if (r_hdr) begin
                        if (i_byte == CH_LF) begin
                            n_hdr = 1'b0;
                            n_ls  = 1'b1;
                        end
                    end else if (r_pcr && i_byte == CH_LF) begin
                        n_pcr = 1'b0;
                        n_ls  = 1'b1;
                    end else begin
                        // a held CR that is not followed by LF becomes a position
                        push_a = r_pcr;
                        n_pcr  = 1'b0;
                        if (i_byte == CH_CR) begin
                            n_pcr = 1'b1;
                            n_ls  = 1'b0;
                        end else if (i_byte == CH_LF) begin
                            n_ls = 1'b1;
                        end else if (r_ls && !r_pcr && i_byte == CH_HEADER) begin
                            finish = 1'b1;
                            n_hdr  = 1'b1;
                            n_ls   = 1'b0;
                        end else begin
                            n_ls   = 1'b0;
                            push_b = 1'b1;
                        end
                    end
                end
                REQ_EOF: begin
                    finish = 1'b1;
                    n_hdr  = 1'b0;
                    n_ls   = 1'b1;
                    n_pcr  = 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Advance the base window by up to two positions, issue the memory operation, update the totals
    always_comb begin
        pa     = seq_push(r_seq, CH_CR);
        seq_a  = push_a ? pa.seq : r_seq;
        pb     = seq_push(seq_a, i_byte);
        n_seq  = push_b ? pb.seq : seq_a;
        n_hex  = r_hex;
        n_seqs = r_seqs;
        o_op.inc  = (push_a && pa.hit) || (push_b && pb.hit);
        o_op.rd   = i_valid && (i_req == REQ_READ);
        o_op.addr = o_op.rd ? i_index : ((push_b && pb.hit) ? pb.seq.window : pa.seq.window);
        if (o_op.inc && r_hex != '1) begin
            n_hex = r_hex + 1'b1;
        end
        if (finish) begin
            if (seq_a.len >= 3'(HEX_LEN) && r_seqs != '1) begin
                n_seqs = r_seqs + 1'b1;
            end
            n_seq = '0;
        end
    end

    // Hold parser state and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq  <= '0;
            r_hdr  <= 1'b0;
            r_ls   <= 1'b1;
            r_pcr  <= 1'b0;
            r_hex  <= '0;
            r_seqs <= '0;
        end else begin
            r_seq  <= n_seq;
            r_hdr  <= n_hdr;
            r_ls   <= n_ls;
            r_pcr  <= n_pcr;
            r_hex  <= n_hex;
            r_seqs <= n_seqs;
        end
    end

    assign o_hex_total = r_hex;
    assign o_seq_total = r_seqs;

endmodule

/* rtl/chac_count_mem.sv */
// Counter memory with read-modify-write pipeline, write forwarding and clearing pass.
// Depends on chac_pkg; takes operations from chac_parser and emits read results.
module chac_count_mem #(
    parameter int COUNT_WIDTH = 32,
    parameter int TOTAL_WIDTH = 48
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  chac_pkg::t_mem_op      i_op,
    input  logic [TOTAL_WIDTH-1:0] i_hex_total,
    input  logic [TOTAL_WIDTH-1:0] i_seq_total,
    output logic                   o_busy,
    output logic                   o_res_valid,
    output logic [COUNT_WIDTH-1:0] o_count,
    output logic [TOTAL_WIDTH-1:0] o_hex_total,
    output logic [TOTAL_WIDTH-1:0] o_seq_total
);
    import chac_pkg::*;

    logic [COUNT_WIDTH-1:0] mem [NUM_CODES];

    logic                   r_clearing;
    logic [CODE_W-1:0]      r_clr_addr;
    t_mem_op                r_s1;
    logic [COUNT_WIDTH-1:0] r_rdata;
    logic [TOTAL_WIDTH-1:0] r_hex, r_seqs;
    logic                   r_fwd_valid;
    logic [CODE_W-1:0]      r_fwd_addr;
    logic [COUNT_WIDTH-1:0] r_fwd_data;

    logic [COUNT_WIDTH-1:0] cur, n_cnt;
    logic                   wr_en;
    logic [CODE_W-1:0]      wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;

    // Take the value written last cycle when it hits the same entry
    always_comb begin
        cur   = (r_fwd_valid && r_fwd_addr == r_s1.addr) ? r_fwd_data : r_rdata;
        n_cnt = (cur != '1) ? cur + 1'b1 : cur;
        wr_en   = r_clearing || r_s1.inc;
        wr_addr = r_clearing ? r_clr_addr : r_s1.addr;
        wr_data = r_clearing ? '0 : n_cnt;
    end

    // Memory write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[i_op.addr];
    end

    // Sweep every entry to zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == CODE_W'(NUM_CODES - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Advance the operation into the modify stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1        <= '0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_s1        <= i_op;
            r_fwd_valid <= r_s1.inc;
        end
        r_fwd_addr <= r_s1.addr;
        r_fwd_data <= n_cnt;
        r_hex      <= i_hex_total;
        r_seqs     <= i_seq_total;
    end

    assign o_busy      = r_clearing;
    assign o_res_valid = r_s1.rd;
    assign o_count     = cur;
    assign o_hex_total = r_hex;
    assign o_seq_total = r_seqs;

endmodule

/* rtl/chac_out_fifo.sv */
// Three-entry result queue in front of the output stream.
// Depends on chac_pkg for the result width.
module chac_out_fifo (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  logic [chac_pkg::OUT_DATA_W-1:0] i_data,
    input  logic                            i_pop,
    output logic                            o_valid,
    output logic [chac_pkg::OUT_DATA_W-1:0] o_data,
    output logic [1:0]                      o_level
);
    import chac_pkg::*;

    localparam logic [1:0] LAST = 2'd2;

    logic [OUT_DATA_W-1:0] r_buf [3];
    logic [1:0]            r_wr, r_rd, r_level;
    logic                  pop;

    assign pop = i_pop && (r_level != 2'd0);

    // Store pushed results
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_data;
        end
    end

    // Advance pointers and level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? 2'd0 : r_wr + 2'd1;
            end
            if (pop) begin
                r_rd <= (r_rd == LAST) ? 2'd0 : r_rd + 2'd1;
            end
            r_level <= r_level + {1'b0, i_push} - {1'b0, pop};
        end
    end

    assign o_valid = (r_level != 2'd0);
    assign o_data  = r_buf[r_rd];
    assign o_level = r_level;

endmodule

/* test/chac_checker.sv */
// Scoreboard for the codon-aligned hexamer counter: follows both stream channels,
// keeps its own copy of the parser, counters and totals, and checks every read result.
// Depends on chac_pkg only.
`timescale 1ns / 100ps

module chac_checker #(
    parameter int COUNT_WIDTH = 32,
    parameter int TOTAL_WIDTH = 48
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    // text_byte [7:0], counter_index [19:8], zero [23:20]
    input  logic [chac_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // req_type [1:0]
    input  logic [chac_pkg::IN_USER_W-1:0]  i_s_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    // count_value [31:0], hexamer_total [79:32], sequence_total [127:80]
    input  logic [chac_pkg::OUT_DATA_W-1:0] i_m_tdata,
    output int                              o_mismatches,
    output int                              o_outstanding,
    output int                              o_reads_checked,
    output logic [63:0]                     o_hexamers,
    output logic [63:0]                     o_sequences
);

    import chac_pkg::*;

    localparam logic [63:0] CNT_MAX  = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - COUNT_WIDTH);
    localparam logic [63:0] TOT_MAX  = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - TOTAL_WIDTH);
    localparam logic [63:0] CNT_MASK = (64'd1 << OUT_CNT_W) - 64'd1;
    localparam logic [63:0] TOT_MASK = (64'd1 << OUT_TOT_W) - 64'd1;

    typedef struct {
        logic [63:0] count;
        logic [63:0] hexes;
        logic [63:0] seqs;
    } t_read_result;

    // Predicted block state
    logic [63:0]       hex_counts [NUM_CODES];
    logic [CODE_W-1:0] win_code;
    logic [5:0]        win_ok;
    logic [1:0]        codon_pos;
    logic [2:0]        run_len;
    logic              in_hdr;
    logic              line_start;
    logic              cr_held;
    logic [63:0]       hex_total;
    logic [63:0]       seq_total;

    t_read_result      read_results [$];

    assign o_hexamers  = hex_total;
    assign o_sequences = seq_total;

    initial begin
        o_mismatches    = 0;
        o_outstanding   = 0;
        o_reads_checked = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
        o_mismatches++;
    endtask

    // Return {valid, code} for one character
    function automatic logic [2:0] decode_base(input logic [7:0] ch);
        case (ch)
            "A", "a": return 3'b100;
            "C", "c": return 3'b101;
            "G", "g": return 3'b110;
            "T", "t": return 3'b111;
            default:  return 3'b000;
        endcase
    endfunction

    task automatic clear_run();
        win_code  = '0;
        win_ok    = '0;
        codon_pos = '0;
        run_len   = '0;
    endtask

    task automatic clear_model();
        for (int i = 0; i < NUM_CODES; i++) hex_counts[i] = '0;
        clear_run();
        in_hdr     = 1'b0;
        line_start = 1'b1;
        cr_held    = 1'b0;
        hex_total  = '0;
        seq_total  = '0;
    endtask

    // Close the current sequence, counting it if it reached six positions
    task automatic end_sequence();
        if (run_len >= 3'(HEX_LEN) && seq_total != TOT_MAX) seq_total++;
        clear_run();
    endtask

    // Take one position; count the window when it closes on a codon boundary
    task automatic shift_base(input logic [7:0] ch);
        logic [2:0] dec;
        dec       = decode_base(ch);
        win_code  = {win_code[CODE_W-3:0], dec[1:0]};
        win_ok    = {win_ok[4:0], dec[2]};
        codon_pos = (codon_pos == 2'(CODON - 1)) ? 2'd0 : codon_pos + 2'd1;
        if (run_len < 3'(HEX_LEN)) run_len++;
        if (codon_pos == 2'd0 && run_len == 3'(HEX_LEN) && win_ok == ALL_VALID) begin
            if (hex_counts[win_code] != CNT_MAX) hex_counts[win_code]++;
            if (hex_total != TOT_MAX) hex_total++;
        end
    endtask

    // Line parser: headers, held CR, line starts
    task automatic take_text(input logic [7:0] ch);
        if (in_hdr) begin
            if (ch == CH_LF) begin
                in_hdr     = 1'b0;
                line_start = 1'b1;
            end
            return;
        end
        if (cr_held) begin
            cr_held = 1'b0;
            if (ch == CH_LF) begin
                line_start = 1'b1;
                return;
            end
            shift_base(CH_CR);
        end
        if (ch == CH_CR) begin
            cr_held    = 1'b1;
            line_start = 1'b0;
        end else if (ch == CH_LF) begin
            line_start = 1'b1;
        end else if (line_start && ch == CH_HEADER) begin
            end_sequence();
            in_hdr     = 1'b1;
            line_start = 1'b0;
        end else begin
            line_start = 1'b0;
            shift_base(ch);
        end
    endtask

    task automatic apply_request(input logic [1:0] kind, input logic [7:0] ch,
                                 input logic [CODE_W-1:0] idx);
        t_read_result res;
        case (kind)
            REQ_TEXT: take_text(ch);
            REQ_EOF: begin
                end_sequence();
                in_hdr     = 1'b0;
                line_start = 1'b1;
                cr_held    = 1'b0;
            end
            REQ_READ: begin
                res.count = hex_counts[idx] & CNT_MASK;
                res.hexes = hex_total & TOT_MASK;
                res.seqs  = seq_total & TOT_MASK;
                read_results = {read_results, res};
            end
            default: ;
        endcase
    endtask

    // Check the output transfer first: it always belongs to an earlier read
    always @(posedge i_clk) begin : watch
        t_read_result want;
        logic [63:0]  got_count;
        logic [63:0]  got_hexes;
        logic [63:0]  got_seqs;
        if (!i_rst_n) begin
            clear_model();
            read_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got_count = 64'(i_m_tdata[OUT_CNT_W-1:0]);
                got_hexes = 64'(i_m_tdata[OUT_CNT_W +: OUT_TOT_W]);
                got_seqs  = 64'(i_m_tdata[OUT_CNT_W + OUT_TOT_W +: OUT_TOT_W]);
                if (read_results.size() == 0) begin
                    report_mismatch("result with no read waiting", got_count, '0);
                end else begin
                    want = read_results.pop_front();
                    if (got_count != want.count)
                        report_mismatch("count_value", got_count, want.count);
                    if (got_hexes != want.hexes)
                        report_mismatch("hexamer_total", got_hexes, want.hexes);
                    if (got_seqs != want.seqs)
                        report_mismatch("sequence_total", got_seqs, want.seqs);
                    o_reads_checked++;
                end
            end
            if (i_s_tvalid && i_s_tready)
                apply_request(i_s_tuser, i_s_tdata[7:0], i_s_tdata[8 +: CODE_W]);
        end
        o_outstanding = read_results.size();
    end

endmodule

/* test/tb_codon_aligned_hexamer_counter.sv */
// Testbench top for the codon-aligned hexamer counter: drives FASTA-like byte streams,
// reads and end-of-file requests with bursty input and a stalling receiver.
// Depends on chac_pkg, codon_aligned_hexamer_counter and chac_checker.
`timescale 1ns / 100ps

module tb_codon_aligned_hexamer_counter;

    import chac_pkg::*;

    localparam int          COUNT_WIDTH  = 32;
    localparam int          TOTAL_WIDTH  = 48;
    localparam int          ITEM_GOAL    = 600;
    localparam int          LONG_HOLD    = 300;
    localparam int          STALL_LIMIT  = 20000;
    localparam int          DRAIN_CYCLES = 8;
    localparam logic [1:0]  REQ_UNUSED   = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [IN_USER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    int                    mismatches;
    int                    outstanding;
    int                    reads_checked;
    logic [63:0]           hexamers;
    logic [63:0]           sequences;

    int                    items_sent;
    int                    burst_left;
    int                    idle_cycles;
    logic                  hold_pending;
    logic [CODE_W-1:0]     recent_code;

    codon_aligned_hexamer_counter #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TOTAL_WIDTH (TOTAL_WIDTH)
    ) u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    chac_checker #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TOTAL_WIDTH (TOTAL_WIDTH)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_s_tuser       (s_tuser),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding),
        .o_reads_checked (reads_checked),
        .o_hexamers      (hexamers),
        .o_sequences     (sequences)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Abort when no transfer happens on either side for too long
    initial idle_cycles = 0;
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("no transfer for %0d cycles", STALL_LIMIT);
            $display("FAIL codon_aligned_hexamer_counter");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random stretches of full rate, light and heavy stalling,
    // plus one long hold-off on request to back the block up
    initial begin : receiver
        int mode;
        int mode_left;
        mode      = 0;
        mode_left = 0;
        forever begin
            @(negedge clk);
            if (hold_pending) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_pending = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(4, 40);
                end
                mode_left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offer one transfer and hold it until taken; bursts sometimes end in random gaps
    task automatic send_item(input logic [1:0] kind, input logic [7:0] ch,
                             input logic [CODE_W-1:0] idx);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, idx, ch};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (kind != REQ_UNUSED) items_sent++;
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic send_text(input logic [7:0] ch);
        send_item(REQ_TEXT, ch, CODE_W'($urandom_range(0, NUM_CODES - 1)));
    endtask

    task automatic send_read(input logic [CODE_W-1:0] idx);
        send_item(REQ_READ, 8'($urandom_range(0, 255)), idx);
    endtask

    task automatic send_eof();
        send_item(REQ_EOF, 8'($urandom_range(0, 255)),
                  CODE_W'($urandom_range(0, NUM_CODES - 1)));
    endtask

    // Mostly the last bases sent, so reads tend to land on live counters
    function automatic logic [CODE_W-1:0] pick_index();
        if ($urandom_range(0, 2) != 0) return recent_code;
        return CODE_W'($urandom_range(0, NUM_CODES - 1));
    endfunction

    // Mostly A/C/G/T in mixed case, sometimes N or an arbitrary byte
    task automatic send_base();
        int          pick;
        logic [1:0]  code;
        logic [7:0]  ch;
        pick = $urandom_range(0, 99);
        if (pick < 90) begin
            code = 2'($urandom_range(0, 3));
            case (code)
                2'd0:    ch = "A";
                2'd1:    ch = "C";
                2'd2:    ch = "G";
                default: ch = "T";
            endcase
            if ($urandom_range(0, 1)) ch = ch | 8'h20;
            recent_code = {recent_code[CODE_W-3:0], code};
        end else if (pick < 97) begin
            ch = "N";
        end else begin
            ch = 8'($urandom_range(0, 255));
        end
        send_text(ch);
    endtask

    task automatic send_line_end();
        if ($urandom_range(0, 2) == 0) send_text(CH_CR);
        send_text(CH_LF);
    endtask

    task automatic send_header();
        send_text(CH_HEADER);
        repeat ($urandom_range(0, 6)) send_text(8'($urandom_range(32, 126)));
        send_line_end();
    endtask

    // Sequence line: sometimes empty, sometimes left open or closed by a stray CR
    task automatic send_line();
        int len;
        int ending;
        len    = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 24);
        ending = $urandom_range(0, 9);
        repeat (len) send_base();
        if (ending < 8)       send_line_end();
        else if (ending == 8) send_text(CH_CR);
    endtask

    initial begin : stimulus
        int pick;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = REQ_TEXT;
        m_tready     = 1'b0;
        hold_pending = 1'b0;
        items_sent   = 0;
        burst_left   = 1;
        recent_code  = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: top index on empty counters, one counted hexamer in mixed case
        send_read({CODE_W{1'b1}});
        send_text("A");
        send_text("c");
        send_text("G");
        send_text("t");
        send_text("a");
        send_text("C");
        // CR before LF, then an empty line
        send_text(CH_CR);
        send_text(CH_LF);
        send_text(CH_LF);
        send_read(12'h1B1);
        // Header closes the sequence
        send_text(CH_HEADER);
        send_text(8'hFF);
        send_text(CH_LF);
        // CR at line start makes the following header mark a plain byte; NUL and FF too
        send_text(CH_CR);
        send_text(CH_HEADER);
        send_text(8'h00);
        send_text(8'hFF);
        // CR dropped by end of file
        send_text(CH_CR);
        send_eof();
        send_item(REQ_UNUSED, 8'hFF, {CODE_W{1'b1}});
        send_read('0);

        // Back-to-back reads against a long receiver hold-off
        hold_pending = 1'b1;
        burst_left   = 100;
        repeat (12) send_read(pick_index());

        // Random records: headers, sequence lines, reads, end of file and noise
        while (items_sent < ITEM_GOAL) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                if ($urandom_range(0, 3) != 0) send_header();
                repeat ($urandom_range(1, 4)) begin
                    send_line();
                    if ($urandom_range(0, 1)) send_read(pick_index());
                end
            end else if (pick < 83) begin
                send_eof();
            end else if (pick < 93) begin
                repeat ($urandom_range(1, 4))
                    send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              CODE_W'($urandom_range(0, NUM_CODES - 1)));
            end else begin
                repeat ($urandom_range(1, 3)) send_read(pick_index());
            end
        end
        s_tvalid <= 1'b0;

        // Drain outstanding reads, then let the pipeline settle
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d requests, checked %0d read results", items_sent, reads_checked);
        $display("predicted %0d hexamers over %0d finished sequences, one long output hold-off",
                 hexamers, sequences);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS codon_aligned_hexamer_counter");
        end else begin
            $display("FAIL codon_aligned_hexamer_counter");
        end
        $finish;
    end

endmodule
